// ----- src/utf8d_pkg.sv -----
// Shared types, constants and helper functions for the padded UTF-8 decoder.
package utf8d_pkg;

    localparam int UNIT_W = 31;
    localparam int LEN_W  = 3;

    typedef logic [UNIT_W-1:0] unit_t;
    typedef logic [LEN_W-1:0]  len_t;

    // One decoded run: the first two units and the total unit count.
    // Every unit after the second one is zero.
    typedef struct packed {
        unit_t unit0;
        unit_t unit1;
        len_t  len;
    } run_t;

    localparam unit_t SUPP_BASE  = 31'h0001_0000;
    localparam unit_t HI_SURR    = 31'h0000_D800;
    localparam unit_t LO_SURR    = 31'h0000_DC00;
    localparam len_t  LEN_SINGLE = 3'd1;
    localparam len_t  LEN_PAIR   = 3'd2;
    localparam len_t  LEN_MAX    = 3'd6;

    // Sequence length from the bits of a lead byte.
    function automatic len_t lead_length(input logic [7:0] b);
        len_t n;
        priority if (!b[7]) n = LEN_SINGLE;
        else if (!b[5])     n = LEN_PAIR;
        else if (!b[4])     n = 3'd3;
        else if (!b[3])     n = 3'd4;
        else if (!b[2])     n = 3'd5;
        else                n = LEN_MAX;
        return n;
    endfunction

    // Payload bits that a lead byte of the given length contributes.
    function automatic logic [7:0] lead_payload(input logic [7:0] b, input len_t n);
        logic [7:0] mask;
        mask = 8'h7F >> n;
        return b & mask;
    endfunction

    // Builds the run for a finished value, splitting it into a surrogate
    // pair when UTF-16 output is selected and the value needs one.
    function automatic run_t make_run(input unit_t v, input len_t n, input logic mode);
        run_t  r;
        unit_t w;
        logic  surr;
        w    = v - SUPP_BASE;
        surr = mode && (v >= SUPP_BASE) && (n >= LEN_PAIR);
        r.len = n;
        if (surr)
        begin
            r.unit0 = HI_SURR | {21'd0, w[19:10]};
            r.unit1 = LO_SURR | {21'd0, w[9:0]};
        end
        else
        begin
            r.unit0 = v;
            r.unit1 = '0;
        end
        return r;
    endfunction

endpackage

// ----- src/utf8d_front.sv -----
// Front end: classifies lead bytes, gathers continuation bytes, and queues finished runs.
module utf8d_front
    import utf8d_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       utf16_mode,
    input  logic       accept,
    input  logic [7:0] in_byte,
    input  logic       end_of_data,
    output logic       push,
    output run_t       push_run
);

    len_t  seq_len_reg, seq_len_next;
    len_t  seen_reg, seen_next;
    unit_t accum_reg, accum_next;

    len_t  lead_n;
    len_t  seen_inc;
    unit_t acc_shift;
    unit_t run_value;
    len_t  run_len;

    assign lead_n    = lead_length(in_byte);
    assign seen_inc  = seen_reg + 3'd1;
    assign acc_shift = {accum_reg[UNIT_W-7:0], in_byte[5:0]};

    always_comb
    begin
        seq_len_next = seq_len_reg;
        seen_next    = seen_reg;
        accum_next   = accum_reg;
        push         = 1'b0;
        run_value    = '0;
        run_len      = lead_n;
        if (accept)
        begin
            if (seq_len_reg == '0)
            begin
                if (lead_n == LEN_SINGLE)
                begin
                    push      = 1'b1;
                    run_value = {23'd0, in_byte};
                end
                else if (end_of_data)
                begin
                    // A lead byte at end of data yields a run of zeros.
                    push = 1'b1;
                end
                else
                begin
                    seq_len_next = lead_n;
                    seen_next    = 3'd1;
                    accum_next   = {23'd0, lead_payload(in_byte, lead_n)};
                end
            end
            else
            begin
                run_len = seq_len_reg;
                if (seen_inc >= seq_len_reg)
                begin
                    push         = 1'b1;
                    run_value    = acc_shift;
                    seq_len_next = '0;
                    seen_next    = '0;
                    accum_next   = '0;
                end
                else if (end_of_data)
                begin
                    push         = 1'b1;
                    seq_len_next = '0;
                    seen_next    = '0;
                    accum_next   = '0;
                end
                else
                begin
                    seen_next  = seen_inc;
                    accum_next = acc_shift;
                end
            end
        end
    end

    assign push_run = make_run(run_value, run_len, utf16_mode);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_len_reg <= '0;
            seen_reg    <= '0;
            accum_reg   <= '0;
        end
        else
        begin
            seq_len_reg <= seq_len_next;
            seen_reg    <= seen_next;
            accum_reg   <= accum_next;
        end
    end

endmodule

// ----- src/utf8d_queue.sv -----
// Short run queue between the front end and the unit expander.
module utf8d_queue
    import utf8d_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  run_t push_run,
    input  logic pop,
    output logic full,
    output logic empty,
    output run_t head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    run_t             slots_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full  = (count_reg == FULL_CNT);
    assign empty = (count_reg == '0);
    assign head  = slots_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots_reg[wr_ptr_reg] <= push_run;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("run pushed into a full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("run popped from an empty queue");

    a_count_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue occupancy did not follow a push");
`endif

endmodule

// ----- src/utf8d_back.sv -----
// Back end: expands each queued run into its code units through an output register.
module utf8d_back
    import utf8d_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  empty,
    input  run_t  head,
    output logic  pop,
    input  logic  out_stall,
    output logic  out_valid,
    output unit_t code_unit,
    output logic  run_last
);

    len_t  idx_reg, idx_next;
    logic  valid_reg, valid_next;
    unit_t unit_reg;
    logic  last_reg;

    logic  load;
    logic  is_last;
    unit_t unit_sel;

    assign load    = !empty && (!valid_reg || !out_stall);
    assign is_last = (idx_reg == head.len - 3'd1);
    assign pop     = load && is_last;

    always_comb
    begin
        unique case (idx_reg)
            3'd0:    unit_sel = head.unit0;
            3'd1:    unit_sel = head.unit1;
            default: unit_sel = '0;
        endcase
    end

    always_comb
    begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
            idx_next   = is_last ? '0 : idx_reg + 3'd1;
        end
        else if (!out_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            unit_reg <= unit_sel;
            last_reg <= is_last;
        end
    end

    assign out_valid = valid_reg;
    assign code_unit = unit_reg;
    assign run_last  = last_reg;

endmodule

// ----- src/utf8_decoder_padded.sv -----
// Top level of the padded UTF-8 decoder: config register, front end, run queue, expander.
// Throughput: one byte accepted and one code unit delivered per cycle when neither side stalls.
// The run of a completing byte is written into the run queue, then its first unit into the output register.
// in_stall rises only while the run queue holds FIFO_DEPTH runs; the expander drains it.
// Reset: no open sequence, empty queue, no valid output, UTF-16 mode off.
// There is no clearing pass; bytes are taken from the first cycle after reset.
module utf8_decoder_padded
    import utf8d_pkg::*;
#(
    parameter int FIFO_DEPTH = 4
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_write_en,
    input  logic                cfg_write_data,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [7:0]          in_byte,
    input  logic                end_of_data,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [UNIT_W-1:0]   code_unit,
    output logic                run_last
);

    // The mode is sampled by the front end when a run is built, which is
    // the byte that completes or cuts short a sequence.
    logic mode_reg;

    logic accept;
    logic push;
    run_t push_run;
    logic pop;
    logic full;
    logic empty;
    run_t head;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= 1'b0;
        end
        else if (cfg_write_en)
        begin
            mode_reg <= cfg_write_data;
        end
    end

    // The input side only looks at queue occupancy, so a stalled output
    // does not stop bytes until the queue actually fills.
    assign in_stall = full;
    assign accept   = in_valid && !full;

    utf8d_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .utf16_mode  (mode_reg),
        .accept      (accept),
        .in_byte     (in_byte),
        .end_of_data (end_of_data),
        .push        (push),
        .push_run    (push_run)
    );

    utf8d_queue #(
        .DEPTH (FIFO_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_run (push_run),
        .pop      (pop),
        .full     (full),
        .empty    (empty),
        .head     (head)
    );

    // Each run of N units leaves the queue after its N-th beat is loaded
    // into the output register.
    utf8d_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .empty     (empty),
        .head      (head),
        .pop       (pop),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .code_unit (code_unit),
        .run_last  (run_last)
    );

endmodule

// ----- test/utf8_decoder_padded_test.sv -----
// Self-checking testbench for the padded UTF-8 decoder with a unit predictor and random handshakes.
module utf8_decoder_padded_test
    import utf8d_pkg::*;
();

    // The limit lies far beyond the length of a correct run, so this only catches a hang.
    localparam int CYCLE_LIMIT   = 200000;
    // Before a unit can be handed over, the completing byte's run passes the run queue and the
    // output register; the settle time covers that and any run still being expanded out of the queue.
    localparam int SETTLE_CYCLES = 4;

    // One expected output beat: the code unit and its end-of-run flag.
    typedef struct {
        unit_t unit;
        logic  last;
    } unit_beat_t;

    // Tracks the decoder state alongside the block and holds the units that the
    // accepted bytes must produce, oldest first.
    class utf8_unit_tracker;
        logic       utf16_mode;
        len_t       open_len;
        len_t       taken;
        unit_t      accum;
        unit_beat_t expected_units[$];
        int         mismatches;

        function new();
            utf16_mode = 1'b0;
            open_len   = '0;
            taken      = '0;
            accum      = '0;
            mismatches = 0;
        endfunction

        // The first clear bit from the top, skipping bit 6, sets the length.
        function len_t class_lead(logic [7:0] b);
            len_t n;
            casez (b)
                8'b0???????: n = 3'd1;
                8'b??0?????: n = 3'd2;
                8'b???0????: n = 3'd3;
                8'b????0???: n = 3'd4;
                8'b?????0??: n = 3'd5;
                default:     n = 3'd6;
            endcase
            return n;
        endfunction

        // Queues n units: the value (or a surrogate pair) and then zeros.
        function void queue_run(unit_t v, len_t n);
            unit_beat_t beat;
            unit_t      w;
            unit_t      first;
            unit_t      second;
            w      = v - SUPP_BASE;
            first  = v;
            second = '0;
            if (utf16_mode && (v >= SUPP_BASE) && (n >= 3'd2))
            begin
                first  = HI_SURR | {21'd0, w[19:10]};
                second = LO_SURR | {21'd0, w[9:0]};
            end
            for (int i = 0; i < n; i++)
            begin
                beat.unit = (i == 0) ? first : ((i == 1) ? second : '0);
                beat.last = (i == n - 1);
                expected_units.insert(expected_units.size(), beat);
            end
        endfunction

        function void accept_byte(logic [7:0] b, logic eod);
            len_t n;
            if (open_len == '0)
            begin
                n = class_lead(b);
                if (n == 3'd1)
                    queue_run(unit_t'(b), n);
                else if (eod)
                    queue_run('0, n);
                else
                begin
                    open_len = n;
                    taken    = 3'd1;
                    accum    = unit_t'(b & (8'h7F >> n));
                end
            end
            else
            begin
                accum = {accum[24:0], b[5:0]};
                taken = taken + 3'd1;
                if (taken >= open_len)
                begin
                    queue_run(accum, open_len);
                    open_len = '0;
                    taken    = '0;
                    accum    = '0;
                end
                else if (eod)
                begin
                    queue_run('0, open_len);
                    open_len = '0;
                    taken    = '0;
                    accum    = '0;
                end
            end
        endfunction

        function void compare_unit(unit_t unit, logic last);
            unit_beat_t want;
            if (expected_units.size() == 0)
            begin
                $error("unexpected unit beat: code_unit %h run_last %b", unit, last);
                mismatches++;
                return;
            end
            want = expected_units.pop_front();
            if (unit !== want.unit)
            begin
                $error("code_unit: expected %h, got %h", want.unit, unit);
                mismatches++;
            end
            if (last !== want.last)
            begin
                $error("run_last: expected %b, got %b", want.last, last);
                mismatches++;
            end
        endfunction
    endclass

    logic              clk;
    logic              rst_n;
    logic              cfg_write_en;
    logic              cfg_write_data;
    logic              in_valid;
    logic              in_stall;
    logic [7:0]        in_byte;
    logic              end_of_data;
    logic              out_valid;
    logic              out_stall;
    logic [UNIT_W-1:0] code_unit;
    logic              run_last;

    utf8_unit_tracker board;
    int               send_idle_pct;
    int               recv_idle_pct;
    int               cycle_count;

    utf8_decoder_padded uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .in_byte        (in_byte),
        .end_of_data    (end_of_data),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .code_unit      (code_unit),
        .run_last       (run_last)
    );

    // Period of 12 time units, low half first.
    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Hang guard. A run that never drains ends here with the failure verdict.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("utf8_decoder_padded: mismatch");
            $finish;
        end
    end

    // The receiver stalls at random with the rate of the current phase. The stall is
    // drawn anew on every edge, so gaps can land on any unit of a run.
    always @(posedge clk)
        out_stall <= ($urandom_range(0, 99) < recv_idle_pct);

    // Every unit beat taken at an edge is checked against the oldest expectation.
    // Outputs are read in the active region of the edge, before the block updates them.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            board.compare_unit(code_unit, run_last);
    end

    // Presents one byte, idling first at the sender's rate, and holds it until the
    // block takes it. The byte goes to the predictor on the edge that accepts it.
    // in_valid stays high on return, so a following byte runs back to back.
    task automatic send_byte(input logic [7:0] b, input logic eod);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        in_byte     <= b;
        end_of_data <= eod;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        board.accept_byte(b, eod);
    endtask

    // Holds the sender off until every expected unit has been taken, then lets the
    // block settle. An open sequence may remain; it produces nothing until more bytes come.
    task automatic drain_units();
        in_valid <= 1'b0;
        @(posedge clk);
        while (board.expected_units.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Writes the mode register while the output side is idle. The predictor switches
    // at the same edge, so a sequence left open finishes under the new mode.
    task automatic write_mode(input logic m);
        drain_units();
        cfg_write_en   <= 1'b1;
        cfg_write_data <= m;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        board.utf16_mode = m;
    endtask

    // Builds a lead byte that announces a sequence of n bytes, payload bits random.
    function automatic logic [7:0] lead_for(input int n);
        logic [7:0] r;
        logic [7:0] b;
        r = 8'($urandom_range(0, 255));
        case (n)
            1:       b = {1'b0, r[6:0]};
            2:       b = {3'b110, r[4:0]};
            3:       b = {4'b1110, r[3:0]};
            4:       b = {5'b11110, r[2:0]};
            5:       b = {6'b111110, r[1:0]};
            default: b = {7'b1111110, r[0]};
        endcase
        return b;
    endfunction

    // Mostly well-formed sequences with random payload, some with an early end of
    // data or a malformed continuation, and some lone random bytes as noise.
    task automatic send_random_bytes(input int count);
        int         sent;
        int         n;
        int         pick;
        logic [7:0] b;
        logic       eod;
        sent = 0;
        while (sent < count)
        begin
            if ($urandom_range(0, 99) < 85)
            begin
                pick = $urandom_range(0, 9);
                n = (pick < 3) ? 1 : (pick < 5) ? 2 : (pick < 7) ? 3 : (pick - 3);
                for (int i = 0; i < n; i++)
                begin
                    if (i == 0)
                        b = lead_for(n);
                    else if ($urandom_range(0, 19) == 0)
                        b = 8'($urandom_range(0, 255));
                    else
                        b = {2'b10, 6'($urandom_range(0, 63))};
                    eod = ($urandom_range(0, 24) == 0);
                    send_byte(b, eod);
                    sent++;
                    // An end of data before the last byte cuts the sequence short.
                    if (eod)
                        break;
                end
            end
            else
            begin
                send_byte(8'($urandom_range(0, 255)), ($urandom_range(0, 3) == 0));
                sent++;
            end
            // Now and then the sender waits for the output side to catch up fully.
            if ($urandom_range(0, 49) == 0)
                drain_units();
        end
    endtask

    initial
    begin
        board          = new();
        cycle_count    = 0;
        send_idle_pct  = 11;
        recv_idle_pct  = 78;
        rst_n          <= 1'b0;
        cfg_write_en   <= 1'b0;
        cfg_write_data <= 1'b0;
        in_valid       <= 1'b0;
        in_byte        <= '0;
        end_of_data    <= 1'b0;
        out_stall      <= 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part in plain 31-bit mode, with the mode written explicitly first.
        write_mode(1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h7F, 1'b1);
        send_byte(8'hC2, 1'b0);
        send_byte(8'hA9, 1'b0);
        // Five-byte sequence.
        send_byte(8'hF8, 1'b0);
        send_byte(8'h88, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h80, 1'b0);
        // Six-byte sequence with every payload bit set: the widest value the unit holds.
        send_byte(8'hFD, 1'b0);
        repeat (5) send_byte(8'hBF, 1'b0);
        // A stray continuation byte in lead position, then an ASCII byte taken as its
        // continuation without any check.
        send_byte(8'h80, 1'b0);
        send_byte(8'h41, 1'b0);
        // Sequences cut short by end of data, in the middle and right at the lead.
        send_byte(8'hE2, 1'b0);
        send_byte(8'h82, 1'b1);
        send_byte(8'hF4, 1'b1);

        // UTF-16 mode: a supplementary character splits into a surrogate pair.
        write_mode(1'b1);
        send_byte(8'hF0, 1'b0);
        send_byte(8'h9F, 1'b0);
        send_byte(8'h98, 1'b0);
        send_byte(8'h80, 1'b0);
        // Mode changed in the middle of a sequence; the mode at the completing byte
        // applies. The completing byte also carries end of data.
        send_byte(8'hF0, 1'b0);
        send_byte(8'h9F, 1'b0);
        write_mode(1'b0);
        send_byte(8'h98, 1'b0);
        send_byte(8'h80, 1'b1);

        // Random part, first phase: the receiver stalls most of the time.
        send_random_bytes(160);

        // Second phase: roles swapped, UTF-16 output.
        write_mode(1'b1);
        send_idle_pct = 78;
        recv_idle_pct = 11;
        send_random_bytes(160);

        // Third phase: no idling at all, through both modes.
        write_mode(1'b0);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        send_random_bytes(66);
        write_mode(1'b1);
        send_random_bytes(56);

        drain_units();
        if (board.mismatches == 0)
            $display("utf8_decoder_padded: match");
        else
            $display("utf8_decoder_padded: mismatch");
        $finish;
    end

endmodule
